@@ rtl/wqss_pkg.sv @@
`timescale 1ns / 1ps

package wqss_pkg;

    localparam int COUNT_BITS = 16;
    localparam int LANE_W     = 16;
    localparam int VAL_W      = COUNT_BITS + 1;
    localparam int PR_W       = 2 * VAL_W;
    localparam int MUL_W      = 34;
    localparam int PROD_W     = 2 * MUL_W;
    localparam int NKIND      = 6;
    localparam int NROLE      = 4;
    localparam int SITE_W     = 100;
    localparam int ACC_W      = 95;
    localparam int SUM_W      = SITE_W + 1;

    localparam logic [2:0] REG_FREQ_A   = 3'd0;
    localparam logic [2:0] REG_FREQ_C   = 3'd1;
    localparam logic [2:0] REG_FREQ_G   = 3'd2;
    localparam logic [2:0] REG_FREQ_T   = 3'd3;
    localparam logic [2:0] REG_TOPOLOGY = 3'd4;

    localparam logic [2:0] KIND_A = 3'd0;
    localparam logic [2:0] KIND_C = 3'd1;
    localparam logic [2:0] KIND_G = 3'd2;
    localparam logic [2:0] KIND_T = 3'd3;
    localparam logic [2:0] KIND_R = 3'd4;
    localparam logic [2:0] KIND_Y = 3'd5;

    typedef struct packed {
        logic [63:0] group0_counts;
        logic [63:0] group1_counts;
        logic [63:0] group2_counts;
        logic [63:0] group3_counts;
        logic        last_in_window;
    } in_t;

    typedef struct packed {
        logic signed [63:0] window_score;
        logic               saturated;
    } out_t;

    typedef struct packed {
        logic [NKIND-1:0][NROLE-1:0][VAL_W-1:0] vals;
        logic                                   last;
    } site_t;

    function automatic logic [2:0] quad_x(input logic [3:0] q);
        logic [2:0] k;
        unique case (q)
            4'd0:    k = KIND_R;
            4'd1:    k = KIND_A;
            4'd2:    k = KIND_G;
            4'd3:    k = KIND_R;
            4'd4:    k = KIND_R;
            4'd5:    k = KIND_A;
            4'd6:    k = KIND_A;
            4'd7:    k = KIND_G;
            default: k = KIND_G;
        endcase
        return k;
    endfunction

    function automatic logic [2:0] quad_y(input logic [3:0] q);
        logic [2:0] k;
        unique case (q)
            4'd0:    k = KIND_Y;
            4'd1:    k = KIND_Y;
            4'd2:    k = KIND_Y;
            4'd3:    k = KIND_C;
            4'd4:    k = KIND_T;
            4'd5:    k = KIND_C;
            4'd6:    k = KIND_T;
            4'd7:    k = KIND_C;
            default: k = KIND_T;
        endcase
        return k;
    endfunction

    function automatic logic [1:0] quad_term(input logic [3:0] q);
        logic [1:0] t;
        unique case (q)
            4'd0:    t = 2'd0;
            4'd1:    t = 2'd1;
            4'd2:    t = 2'd1;
            4'd3:    t = 2'd2;
            4'd4:    t = 2'd2;
            default: t = 2'd3;
        endcase
        return t;
    endfunction

    function automatic logic [31:0] weight_sat(input logic [PROD_W-1:0] p);
        logic [31:0] w;
        if (p[PROD_W-1:65] != '0) begin
            w = 32'hFFFF_FFFF;
        end else begin
            w = p[64:33];
        end
        return w;
    endfunction

endpackage

@@ rtl/wqss_front.sv @@
`timescale 1ns / 1ps

module wqss_front (
    input  wqss_pkg::in_t   s_data,
    input  logic [1:0]      topology,
    output wqss_pkg::site_t site
);

    logic [3:0][63:0] grp;
    logic [3:0][1:0]  sel;
    logic [63:0]      v;

    always_comb begin
        grp = {s_data.group3_counts, s_data.group2_counts,
               s_data.group1_counts, s_data.group0_counts};
        unique case (topology)
            2'd1:    sel = {2'd2, 2'd0, 2'd3, 2'd1};
            2'd2:    sel = {2'd1, 2'd0, 2'd3, 2'd2};
            default: sel = {2'd2, 2'd1, 2'd3, 2'd0};
        endcase
        site.last = s_data.last_in_window;
        v = '0;
        for (int k = 0; k < wqss_pkg::NROLE; k++) begin
            v = grp[sel[k]];
            site.vals[wqss_pkg::KIND_A][k] =
                wqss_pkg::VAL_W'(v[0 +: wqss_pkg::COUNT_BITS]);
            site.vals[wqss_pkg::KIND_C][k] =
                wqss_pkg::VAL_W'(v[wqss_pkg::LANE_W +: wqss_pkg::COUNT_BITS]);
            site.vals[wqss_pkg::KIND_G][k] =
                wqss_pkg::VAL_W'(v[2*wqss_pkg::LANE_W +: wqss_pkg::COUNT_BITS]);
            site.vals[wqss_pkg::KIND_T][k] =
                wqss_pkg::VAL_W'(v[3*wqss_pkg::LANE_W +: wqss_pkg::COUNT_BITS]);
            site.vals[wqss_pkg::KIND_R][k] =
                site.vals[wqss_pkg::KIND_A][k] + site.vals[wqss_pkg::KIND_G][k];
            site.vals[wqss_pkg::KIND_Y][k] =
                site.vals[wqss_pkg::KIND_C][k] + site.vals[wqss_pkg::KIND_T][k];
        end
    end

endmodule

@@ rtl/wqss_fifo.sv @@
`timescale 1ns / 1ps

module wqss_fifo (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  wqss_pkg::site_t push_data,
    output logic            full,
    input  logic            pop,
    output logic            empty,
    output wqss_pkg::site_t pop_data
);

    wqss_pkg::site_t mem_reg [2];
    logic            wptr_reg;
    logic            rptr_reg;
    logic [1:0]      count_reg;

    assign full     = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign pop_data = mem_reg[rptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end else begin
            if (push) begin
                wptr_reg <= ~wptr_reg;
            end
            if (pop) begin
                rptr_reg <= ~rptr_reg;
            end
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wptr_reg] <= push_data;
        end
    end

endmodule

@@ rtl/wqss_back.sv @@
`timescale 1ns / 1ps

module wqss_back (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic [15:0]     freq_a,
    input  logic [15:0]     freq_c,
    input  logic [15:0]     freq_g,
    input  logic [15:0]     freq_t,
    input  logic            q_empty,
    input  wqss_pkg::site_t q_data,
    output logic            q_pop,
    output logic            m_valid,
    input  logic            m_ready,
    output wqss_pkg::out_t  m_data
);

    typedef enum logic [2:0] {
        S_IDLE, S_WGT, S_PAIR, S_QUAD, S_TERM, S_ACC
    } state_t;

    state_t                           state_reg;
    logic [4:0]                       step_reg;
    wqss_pkg::site_t                  item_reg;
    logic [wqss_pkg::PR_W-1:0]        pr_reg [wqss_pkg::NKIND][2];
    logic [63:0]                      tsum_reg [4];
    logic [31:0]                      w_reg [4];
    logic [wqss_pkg::MUL_W-1:0]       rsq_reg, ysq_reg, r2_reg, y2_reg, tmp_reg;
    logic [95:0]                      prod_reg;
    logic signed [wqss_pkg::SITE_W-1:0] site_reg;
    logic signed [wqss_pkg::ACC_W-1:0]  acc_reg;
    logic                             sat_reg;
    logic                             m_valid_reg;
    wqss_pkg::out_t                   m_data_reg;

    logic [wqss_pkg::MUL_W-1:0]  mul_a, mul_b;
    logic [wqss_pkg::PROD_W-1:0] prod;
    logic [16:0]                 fr, fy;
    logic [2:0]                  pk, qx, qy;
    logic                        ph;
    logic [3:0]                  qi;
    logic [1:0]                  qt, ti;
    logic [63:0]                 mag;
    logic                        neg;
    logic signed [wqss_pkg::SUM_W-1:0] sum;
    logic signed [wqss_pkg::SUM_W-1:0] acc_max, acc_min;
    logic signed [wqss_pkg::ACC_W-1:0] acc_next;
    logic                        sat_next;
    logic                        out_blocked;
    logic                        load_out;

    assign q_pop   = (state_reg == S_IDLE) && !q_empty;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_comb begin
        fr  = {1'b0, freq_a} + {1'b0, freq_g};
        fy  = {1'b0, freq_c} + {1'b0, freq_t};
        pk  = step_reg[3:1];
        ph  = step_reg[0];
        qi  = step_reg[4:1];
        qx  = wqss_pkg::quad_x(qi);
        qy  = wqss_pkg::quad_y(qi);
        qt  = wqss_pkg::quad_term(qi);
        ti  = step_reg[3:2];
        mag = tsum_reg[ti][63] ? (~tsum_reg[ti] + 64'd1) : tsum_reg[ti];
        neg = tsum_reg[ti][63] ^ ((ti == 2'd1) || (ti == 2'd2));
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_WGT: begin
                unique case (step_reg)
                    5'd0: begin
                        mul_a = wqss_pkg::MUL_W'(fr);
                        mul_b = wqss_pkg::MUL_W'(fr);
                    end
                    5'd1: begin
                        mul_a = wqss_pkg::MUL_W'(fy);
                        mul_b = wqss_pkg::MUL_W'(fy);
                    end
                    5'd2: begin
                        mul_a = wqss_pkg::MUL_W'(freq_a);
                        mul_b = wqss_pkg::MUL_W'(freq_a);
                    end
                    5'd3: begin
                        mul_a = wqss_pkg::MUL_W'(freq_g);
                        mul_b = wqss_pkg::MUL_W'(freq_g);
                    end
                    5'd4: begin
                        mul_a = wqss_pkg::MUL_W'(freq_c);
                        mul_b = wqss_pkg::MUL_W'(freq_c);
                    end
                    5'd5: begin
                        mul_a = wqss_pkg::MUL_W'(freq_t);
                        mul_b = wqss_pkg::MUL_W'(freq_t);
                    end
                    5'd6: begin
                        mul_a = r2_reg;
                        mul_b = y2_reg;
                    end
                    5'd7: begin
                        mul_a = rsq_reg;
                        mul_b = y2_reg;
                    end
                    5'd8: begin
                        mul_a = r2_reg;
                        mul_b = ysq_reg;
                    end
                    default: begin
                        mul_a = rsq_reg;
                        mul_b = ysq_reg;
                    end
                endcase
            end
            S_PAIR: begin
                mul_a = wqss_pkg::MUL_W'(item_reg.vals[pk][{ph, 1'b0}]);
                mul_b = wqss_pkg::MUL_W'(item_reg.vals[pk][{ph, 1'b1}]);
            end
            S_QUAD: begin
                if (!ph) begin
                    mul_a = wqss_pkg::MUL_W'(pr_reg[qx][0]);
                    mul_b = wqss_pkg::MUL_W'(pr_reg[qy][1]);
                end else begin
                    mul_a = wqss_pkg::MUL_W'(pr_reg[qy][0]);
                    mul_b = wqss_pkg::MUL_W'(pr_reg[qx][1]);
                end
            end
            S_TERM: begin
                mul_a = step_reg[0] ? wqss_pkg::MUL_W'(mag[63:32])
                                    : wqss_pkg::MUL_W'(mag[31:0]);
                mul_b = wqss_pkg::MUL_W'(w_reg[ti]);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        prod = mul_a * mul_b;
    end

    always_comb begin
        acc_max  = (wqss_pkg::SUM_W'(1) <<< (wqss_pkg::ACC_W - 1)) - wqss_pkg::SUM_W'(1);
        acc_min  = -(wqss_pkg::SUM_W'(1) <<< (wqss_pkg::ACC_W - 1));
        sum      = wqss_pkg::SUM_W'(acc_reg) + wqss_pkg::SUM_W'(site_reg);
        sat_next = sat_reg;
        priority if (sum > acc_max) begin
            acc_next = acc_max[wqss_pkg::ACC_W-1:0];
            sat_next = 1'b1;
        end else if (sum < acc_min) begin
            acc_next = acc_min[wqss_pkg::ACC_W-1:0];
            sat_next = 1'b1;
        end else begin
            acc_next = sum[wqss_pkg::ACC_W-1:0];
        end
        out_blocked = item_reg.last && m_valid_reg && !m_ready;
        load_out    = (state_reg == S_ACC) && item_reg.last && !out_blocked;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            step_reg    <= '0;
            acc_reg     <= '0;
            sat_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (!q_empty) begin
                        item_reg  <= q_data;
                        for (int i = 0; i < 4; i++) begin
                            tsum_reg[i] <= '0;
                        end
                        site_reg  <= '0;
                        step_reg  <= '0;
                        state_reg <= S_WGT;
                    end
                end
                S_WGT: begin
                    unique case (step_reg)
                        5'd0:    rsq_reg  <= prod[wqss_pkg::MUL_W-1:0];
                        5'd1:    ysq_reg  <= prod[wqss_pkg::MUL_W-1:0];
                        5'd2:    tmp_reg  <= prod[wqss_pkg::MUL_W-1:0];
                        5'd3:    r2_reg   <= tmp_reg + prod[wqss_pkg::MUL_W-1:0];
                        5'd4:    tmp_reg  <= prod[wqss_pkg::MUL_W-1:0];
                        5'd5:    y2_reg   <= tmp_reg + prod[wqss_pkg::MUL_W-1:0];
                        5'd6:    w_reg[0] <= wqss_pkg::weight_sat(prod);
                        5'd7:    w_reg[1] <= wqss_pkg::weight_sat(prod);
                        5'd8:    w_reg[2] <= wqss_pkg::weight_sat(prod);
                        default: w_reg[3] <= wqss_pkg::weight_sat(prod);
                    endcase
                    if (step_reg == 5'd9) begin
                        step_reg  <= '0;
                        state_reg <= S_PAIR;
                    end else begin
                        step_reg <= step_reg + 5'd1;
                    end
                end
                S_PAIR: begin
                    pr_reg[pk][ph] <= prod[wqss_pkg::PR_W-1:0];
                    if (step_reg == 5'd11) begin
                        step_reg  <= '0;
                        state_reg <= S_QUAD;
                    end else begin
                        step_reg <= step_reg + 5'd1;
                    end
                end
                S_QUAD: begin
                    tsum_reg[qt] <= tsum_reg[qt] + prod[63:0];
                    if (step_reg == 5'd17) begin
                        step_reg  <= '0;
                        state_reg <= S_TERM;
                    end else begin
                        step_reg <= step_reg + 5'd1;
                    end
                end
                S_TERM: begin
                    unique case (step_reg[1:0])
                        2'd0: begin
                            prod_reg <= {32'd0, prod[63:0]};
                            step_reg <= step_reg + 5'd1;
                        end
                        2'd1: begin
                            prod_reg <= prod_reg + {prod[63:0], 32'd0};
                            step_reg <= step_reg + 5'd1;
                        end
                        default: begin
                            if (neg) begin
                                site_reg <= site_reg - wqss_pkg::SITE_W'(prod_reg);
                            end else begin
                                site_reg <= site_reg + wqss_pkg::SITE_W'(prod_reg);
                            end
                            if (ti == 2'd3) begin
                                step_reg  <= '0;
                                state_reg <= S_ACC;
                            end else begin
                                step_reg <= step_reg + 5'd2;
                            end
                        end
                    endcase
                end
                default: begin
                    if (!out_blocked) begin
                        if (item_reg.last) begin
                            m_data_reg.window_score <= acc_next[wqss_pkg::ACC_W-1:31];
                            m_data_reg.saturated    <= sat_next;
                            acc_reg                 <= '0;
                            sat_reg                 <= 1'b0;
                        end else begin
                            acc_reg <= acc_next;
                            sat_reg <= sat_next;
                        end
                        state_reg <= S_IDLE;
                    end
                end
            endcase
        end
    end

endmodule

@@ rtl/windowed_quartet_site_score_core.sv @@
`timescale 1ns / 1ps

// Scores one alignment site per input beat and emits one window score on the
// beat flagged last_in_window. The front end permutes the four groups by
// topology and forms the A,C,G,T,purine,pyrimidine counts; a two-entry queue
// hands sites to a back-end sequencer built around one shared 34x34
// multiplier. For each site the back end takes it from the queue, then runs
// 10 weight steps, 12 pair products, 18 quad products, 12
// weighted-term steps and one accumulate. Up to two sites wait in the queue
// while the back end works, and a finished window score waits in the output
// register. Configuration is written over the cfg port (index 0..3
// freq_a..freq_t, 4 topology); write it only while no site is in flight.

module windowed_quartet_site_score_core (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  wqss_pkg::in_t  s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output wqss_pkg::out_t m_data,
    input  logic           cfg_valid,
    output logic           cfg_ready,
    input  logic [2:0]     cfg_index,
    input  logic [15:0]    cfg_data
);

    logic [15:0]     freq_a_reg, freq_c_reg, freq_g_reg, freq_t_reg;
    logic [1:0]      topology_reg;
    wqss_pkg::site_t front_site;
    wqss_pkg::site_t q_data;
    logic            q_full, q_empty, q_pop, push;

    assign cfg_ready = 1'b1;
    assign s_ready   = !q_full;
    assign push      = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            freq_a_reg   <= 16'd16384;
            freq_c_reg   <= 16'd16384;
            freq_g_reg   <= 16'd16384;
            freq_t_reg   <= 16'd16384;
            topology_reg <= 2'd0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                wqss_pkg::REG_FREQ_A:   freq_a_reg   <= cfg_data;
                wqss_pkg::REG_FREQ_C:   freq_c_reg   <= cfg_data;
                wqss_pkg::REG_FREQ_G:   freq_g_reg   <= cfg_data;
                wqss_pkg::REG_FREQ_T:   freq_t_reg   <= cfg_data;
                wqss_pkg::REG_TOPOLOGY: topology_reg <= cfg_data[1:0];
                default: ;
            endcase
        end
    end

    wqss_front u_front (
        .s_data   (s_data),
        .topology (topology_reg),
        .site     (front_site)
    );

    wqss_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (front_site),
        .full      (q_full),
        .pop       (q_pop),
        .empty     (q_empty),
        .pop_data  (q_data)
    );

    wqss_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .freq_a  (freq_a_reg),
        .freq_c  (freq_c_reg),
        .freq_g  (freq_g_reg),
        .freq_t  (freq_t_reg),
        .q_empty (q_empty),
        .q_data  (q_data),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule
